### hw/rtl/sdlp_pkg.sv
// sdlp_pkg: shared constants and payload types for the strided dda line point generator
// used by strided_dda_line_points and its testbench; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdlp_pkg;

    localparam int COORD_BITS      = 12;
    localparam int STRIDE_BITS     = 8;
    localparam int MAX_POINTS_DEF  = 64;
    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(1);

    // segment item, one endpoint pair
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_seg_in;

    // brush position item
    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
        logic                         truncated;
    } t_point_out;

endpackage

`default_nettype wire

### hw/rtl/sdlp_div.sv
// sdlp_div: iterative restoring divider, one quotient bit per cycle
// unsigned operands; standalone, no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module sdlp_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quotient,
    output logic [DEN_W-1:0]      o_remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   n_shift;
    logic             n_fit;
    logic [DEN_W:0]   n_sub;

    always_comb begin
        n_shift = {r_rem[DEN_W-1:0], r_dvd[NUM_W-1]};
        n_fit   = n_shift >= {1'b0, r_den};
        n_sub   = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? n_sub : n_shift;
            r_dvd <= {r_dvd[NUM_W-2:0], n_fit};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem[DEN_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/strided_dda_line_points.sv
// strided_dda_line_points: an accepted segment passes the orient, multiply and bit-serial setup
// divide steps before its first point; points then follow one per cycle.
// busy stays high while a segment is worked on; busy drops with the last point
// and the next segment may be accepted while that point is still on the outputs.
// every point is shown for exactly one cycle on o_point_valid, the receiver cannot stall.
// sync active-low reset returns to idle and sets the stride register to 1; uses sdlp_pkg, sdlp_div
`timescale 1ns / 1ps
`default_nettype none

module strided_dda_line_points #(
    parameter int MAX_POINTS = sdlp_pkg::MAX_POINTS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // segment command
    input  wire logic                                start,
    output logic                                     busy,
    input  wire sdlp_pkg::t_seg_in                   i_seg,
    // point stream
    output logic                                     o_point_valid,
    output sdlp_pkg::t_point_out                     o_point,
    // stride register
    input  wire logic                                i_cfg_we,
    input  wire logic [sdlp_pkg::STRIDE_BITS-1:0]    i_cfg_wdata
);

    import sdlp_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int SW    = STRIDE_BITS;
    localparam int DW    = C + SW;          // width of stride * |dminor|
    localparam int QW    = SW + 2;          // signed per-step quotient
    localparam int ACC_W = C + 2;           // minor accumulator
    localparam int CNT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ORIENT = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state;

    // stride register, zero behaves as one
    logic [SW-1:0] r_stride;
    logic [SW-1:0] s_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            r_stride <= i_cfg_wdata;
        end
    end

    assign s_eff = (r_stride == '0) ? SW'(1) : r_stride;

    // captured endpoints and raw deltas
    logic signed [C-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [C:0]   r_dx, r_dy;

    // oriented segment: major rises from maj0
    logic                r_x_major;
    logic signed [C-1:0] r_maj0;
    logic signed [C-1:0] r_min0;
    logic [C-1:0]        r_dmaj;
    logic signed [C:0]   r_dmin;

    // setup product and per-step increment (floor division of stride*dmin by dmaj)
    logic [DW-1:0]       r_prod;
    logic                r_div_start;
    logic signed [QW-1:0] r_step_q;
    logic [C-1:0]        r_step_r;

    // running walk state
    logic [C:0]              r_off;
    logic signed [ACC_W-1:0] r_q;
    logic [C-1:0]            r_r;
    logic [CNT_W-1:0]        r_n;

    logic                    r_out_valid;
    t_point_out              r_out;

    // ------------------------------------------------------------------
    // orientation: pick the major axis (ties go to y), swap so major rises
    // ------------------------------------------------------------------
    logic [C-1:0]        adx, ady;
    logic                n_x_major;
    logic signed [C:0]   dmaj_raw, dmin_raw;
    logic                n_swap;
    logic signed [C:0]   n_dmaj_s;
    logic signed [C:0]   n_dmin;
    logic signed [C-1:0] n_maj0, n_min0;

    always_comb begin
        adx       = r_dx[C] ? C'(-r_dx) : r_dx[C-1:0];
        ady       = r_dy[C] ? C'(-r_dy) : r_dy[C-1:0];
        n_x_major = adx > ady;
        dmaj_raw  = n_x_major ? r_dx : r_dy;
        dmin_raw  = n_x_major ? r_dy : r_dx;
        n_swap    = dmaj_raw[C];
        n_dmaj_s  = n_swap ? -dmaj_raw : dmaj_raw;
        n_dmin    = n_swap ? -dmin_raw : dmin_raw;
        if (n_x_major) begin
            n_maj0 = n_swap ? r_bx : r_ax;
            n_min0 = n_swap ? r_by : r_ay;
        end else begin
            n_maj0 = n_swap ? r_by : r_ay;
            n_min0 = n_swap ? r_bx : r_ax;
        end
    end

    // magnitude of the minor delta for the setup product
    logic [C-1:0] abs_dmin;
    assign abs_dmin = r_dmin[C] ? C'(-r_dmin) : r_dmin[C-1:0];

    // ------------------------------------------------------------------
    // setup divider
    // ------------------------------------------------------------------
    logic          div_done;
    logic [DW-1:0] div_quot;
    logic [C-1:0]  div_rem;

    sdlp_div #(
        .NUM_W (DW),
        .DEN_W (C)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_prod),
        .i_divisor   (r_dmaj),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // turn the magnitude quotient into a floor quotient with a non-negative remainder
    logic signed [QW-1:0] q_abs;
    logic                 rem_nz;
    logic signed [QW-1:0] n_step_q;
    logic [C-1:0]         n_step_r;

    always_comb begin
        q_abs  = $signed(div_quot[QW-1:0]);
        rem_nz = div_rem != '0;
        if (r_dmin[C] && rem_nz) begin
            n_step_q = -q_abs - QW'(1);
            n_step_r = r_dmaj - div_rem;
        end else if (r_dmin[C]) begin
            n_step_q = -q_abs;
            n_step_r = div_rem;
        end else begin
            n_step_q = q_abs;
            n_step_r = div_rem;
        end
    end

    // ------------------------------------------------------------------
    // walk: one add and compare per point
    // ------------------------------------------------------------------
    logic [C:0]              n_off;
    logic                    span_end;
    logic                    cap_end;
    logic                    n_last;
    logic signed [ACC_W-1:0] mn_floor;
    logic signed [ACC_W-1:0] mn;
    logic [C-1:0]            mj;
    logic [C:0]              rr;
    logic                    wrap;
    logic [C-1:0]            n_r;
    logic signed [ACC_W-1:0] n_q;

    always_comb begin
        n_off    = r_off + (C+1)'(s_eff);
        span_end = n_off > {1'b0, r_dmaj};
        cap_end  = r_n == CNT_W'(MAX_POINTS - 1);
        n_last   = span_end || cap_end;

        // floor of the exact minor, bumped by one when negative and inexact (truncate to zero)
        mn_floor = ACC_W'(r_min0) + r_q;
        mn       = mn_floor + ACC_W'((r_r != '0) && mn_floor[ACC_W-1]);
        mj       = r_maj0 + r_off[C-1:0];

        // advance the floor quotient and remainder by one stride
        rr   = {1'b0, r_r} + {1'b0, r_step_r};
        wrap = rr >= {1'b0, r_dmaj};
        n_r  = wrap ? C'(rr - {1'b0, r_dmaj}) : rr[C-1:0];
        n_q  = r_q + ACC_W'(r_step_q) + ACC_W'(wrap);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_ORIENT;
                    end
                end
                S_ORIENT: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    if (n_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // capture endpoints and raw deltas with the accepted item
                r_ax <= i_seg.start_x;
                r_ay <= i_seg.start_y;
                r_bx <= i_seg.end_x;
                r_by <= i_seg.end_y;
                r_dx <= {i_seg.end_x[C-1], i_seg.end_x} - {i_seg.start_x[C-1], i_seg.start_x};
                r_dy <= {i_seg.end_y[C-1], i_seg.end_y} - {i_seg.start_y[C-1], i_seg.start_y};
            end
            S_ORIENT: begin
                r_x_major <= n_x_major;
                r_maj0    <= n_maj0;
                r_min0    <= n_min0;
                r_dmaj    <= n_dmaj_s[C-1:0];
                r_dmin    <= n_dmin;
            end
            S_MUL: begin
                r_prod <= DW'(abs_dmin) * DW'(s_eff);
            end
            S_DIV: begin
                r_step_q <= n_step_q;
                r_step_r <= n_step_r;
                r_off    <= '0;
                r_q      <= '0;
                r_r      <= '0;
                r_n      <= '0;
            end
            S_EMIT: begin
                r_out.point_x    <= r_x_major ? mj : mn[C-1:0];
                r_out.point_y    <= r_x_major ? mn[C-1:0] : mj;
                r_out.last_point <= n_last;
                r_out.truncated  <= cap_end && !span_end;
                r_off <= n_off;
                r_q   <= n_q;
                r_r   <= n_r;
                r_n   <= r_n + CNT_W'(1);
            end
            default: begin
                r_off <= r_off;
            end
        endcase
    end

    assign busy          = r_state != S_IDLE;
    assign o_point_valid = r_out_valid;
    assign o_point       = r_out;

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for strided_dda_line_points
// drives segment items through start/busy and checks every brush point against an exact-ratio
// predictor; depends on sdlp_pkg and the block rtl
`timescale 1ns / 1ps

module tb_top;
    import sdlp_pkg::*;

    localparam int MAX_POINTS     = 64;
    localparam int NUM_DIR        = 23;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 26;
    localparam int MAX_GAP        = 30;
    localparam int SETTLE_CYCLES  = 30;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // directed segments: start x/y, end x/y, typed flag, then the typed point
    // (x, y, last, truncated); typed rows are zero-length, so one point each
    localparam int DIR_TAB [NUM_DIR][9] = '{
        '{    0,     0,     0,     0, 1,     0,     0, 1, 0},
        '{ 2047,  2047,  2047,  2047, 1,  2047,  2047, 1, 0},
        '{-2048, -2048, -2048, -2048, 1, -2048, -2048, 1, 0},
        '{-2048,  2047, -2048,  2047, 1, -2048,  2047, 1, 0},
        '{    0,     0,     5,     0, 0, 0, 0, 0, 0},  // plain x-major run
        '{    5,     3,    -2,     1, 0, 0, 0, 0, 0},  // endpoints swapped
        '{    0,    -3,     0,     3, 0, 0, 0, 0, 0},  // vertical
        '{    0,     0,     4,     4, 0, 0, 0, 0, 0},  // tie goes to y
        '{    3,    -3,    -3,     3, 0, 0, 0, 0, 0},  // tie, falling
        '{    0,     0,     7,    -3, 0, 0, 0, 0, 0},  // negative slope truncation
        '{   -5,    -5,     2,    -7, 0, 0, 0, 0, 0},  // negative minor toward zero
        '{    0,     0,    63,    10, 0, 0, 0, 0, 0},  // exactly the point limit
        '{    0,     0,    64,    10, 0, 0, 0, 0, 0},  // one past the limit
        '{-2048,     0,  2047,     5, 0, 0, 0, 0, 0},  // full x span
        '{  100, -2048,  -100,  2047, 0, 0, 0, 0, 0},  // full y span
        '{-2048, -2048,  2047,  2047, 0, 0, 0, 0, 0},  // corner to corner
        '{ 2047, -2048, -2048,  2047, 0, 0, 0, 0, 0},
        '{ 2047,     0, -2048,    -1, 0, 0, 0, 0, 0},
        '{    0,     0,     1,     0, 0, 0, 0, 0, 0},  // single step
        '{    0,     0,     1,     1, 0, 0, 0, 0, 0},
        '{ 1000, -2048,  1001,  2047, 0, 0, 0, 0, 0},
        '{   -7,    20,    -7,   -43, 0, 0, 0, 0, 0},  // 64 points, reversed y
        '{ 2047, -2048,  2047, -2048, 1,  2047, -2048, 1, 0}
    };

    // random phases: stride written first (-1 picks one at random), then sender idle percent
    localparam int PHASE_STRIDE [NUM_PHASES] = '{1,  1,  0, 255,  3, 64, -1,  2};
    localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 70, 29,   0, 70, 29,  0, 29};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_seg_in                i_seg;
    logic                   o_point_valid;
    t_point_out             o_point;
    logic                   i_cfg_we;
    logic [STRIDE_BITS-1:0] i_cfg_wdata;

    // testbench copy of the stride register
    logic [STRIDE_BITS-1:0] stride_reg;
    // brush points still owed by the block, oldest first
    t_point_out             expected_points[$];

    int idle_pct;
    int mismatches;
    int points_checked;
    int truncated_seen;
    int segments_sent;
    int strides_used;
    int quiet_cycles;

    strided_dda_line_points #(
        .MAX_POINTS   (MAX_POINTS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_seg        (i_seg),
        .o_point_valid(o_point_valid),
        .o_point      (o_point),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // walk the major axis in stride steps; minor is the exact ratio truncated toward zero
    function automatic void predict_brush_points(t_seg_in seg);
        longint     ax, ay, bx, by, maj0, maj1, min0, min1, swap;
        longint     dmaj, dmin, step, total, count, off, mj, mn;
        bit         x_major, cut;
        t_point_out pt;
        ax = longint'($signed(seg.start_x));
        ay = longint'($signed(seg.start_y));
        bx = longint'($signed(seg.end_x));
        by = longint'($signed(seg.end_y));
        x_major = ((ax > bx) ? ax - bx : bx - ax) > ((ay > by) ? ay - by : by - ay);
        if (x_major) begin
            maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
        end else begin
            maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
        end
        // major coordinate must rise
        if (maj0 > maj1) begin
            swap = maj0; maj0 = maj1; maj1 = swap;
            swap = min0; min0 = min1; min1 = swap;
        end
        dmaj  = maj1 - maj0;
        dmin  = min1 - min0;
        step  = (stride_reg == '0) ? 1 : longint'(stride_reg);  // zero stride acts as one
        total = dmaj / step + 1;
        cut   = total > MAX_POINTS;
        count = cut ? MAX_POINTS : total;
        for (longint n = 0; n < count; n++) begin
            off = n * step;
            mj  = maj0 + off;
            mn  = (dmaj == 0) ? min0 : (min0 * dmaj + off * dmin) / dmaj;
            pt.point_x    = x_major ? mj[COORD_BITS-1:0] : mn[COORD_BITS-1:0];
            pt.point_y    = x_major ? mn[COORD_BITS-1:0] : mj[COORD_BITS-1:0];
            pt.last_point = (n == count - 1);
            pt.truncated  = (n == count - 1) && cut;
            expected_points.push_back(pt);
        end
    endfunction

    // mix of fully random, zero-length, tied, axis-aligned and short segments;
    // short ones reach about 70 strides so the point limit is hit now and then
    function automatic t_seg_in random_segment(int step);
        logic [63:0] raw;
        int          sx, sy, dx, dy, reach, kind;
        t_seg_in     s;
        raw   = {$urandom, $urandom};
        kind  = $urandom_range(99);
        sx    = int'($urandom_range(4095)) - 2048;
        sy    = int'($urandom_range(4095)) - 2048;
        reach = (step * 70 > 2047) ? 2047 : step * 70;
        dx    = int'($urandom_range(reach));
        dy    = int'($urandom_range(reach));
        if (kind < 25)
            return raw[47:0];
        if (kind < 35) begin
            dx = 0;
            dy = 0;
        end else if (kind < 50) begin
            dy = dx;
        end else if (kind < 60) begin
            if (kind[0])
                dx = 0;
            else
                dy = 0;
        end
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
        // with reach below 2048 one of the two directions always stays in range
        if (sx + dx > 2047 || sx + dx < -2048) dx = -dx;
        if (sy + dy > 2047 || sy + dy < -2048) dy = -dy;
        s.start_x = COORD_BITS'(sx);
        s.start_y = COORD_BITS'(sy);
        s.end_x   = COORD_BITS'(sx + dx);
        s.end_y   = COORD_BITS'(sy + dy);
        return s;
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken,
    // with start still high so a following item can go out back to back
    task automatic send_segment(t_seg_in seg, bit typed, t_point_out typed_pt);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
            gap++;
        end
        start <= 1'b1;
        i_seg <= seg;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        if (typed)
            expected_points.push_back(typed_pt);
        else
            predict_brush_points(seg);
        segments_sent++;
        @(negedge i_clk);
    endtask

    // stride only changes with the block idle and every point delivered
    task automatic write_stride(logic [STRIDE_BITS-1:0] value);
        start <= 1'b0;
        while (expected_points.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        stride_reg   = value;
        strides_used++;
    endtask

    // point checker: the receiver cannot stall, so every strobe is an accepted item
    always @(posedge i_clk) begin
        t_point_out want;
        if (i_rst_n === 1'b1 && o_point_valid === 1'b1) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected point x=%0d y=%0d last=%0b trunc=%0b",
                             $signed(o_point.point_x), $signed(o_point.point_y),
                             o_point.last_point, o_point.truncated);
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_point.point_x !== want.point_x || o_point.point_y !== want.point_y ||
                    o_point.last_point !== want.last_point ||
                    o_point.truncated !== want.truncated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("point mismatch: got x=%0d y=%0d last=%0b trunc=%0b",
                                 $signed(o_point.point_x), $signed(o_point.point_y),
                                 o_point.last_point, o_point.truncated,
                                 ", want x=%0d y=%0d last=%0b trunc=%0b",
                                 $signed(want.point_x), $signed(want.point_y),
                                 want.last_point, want.truncated);
                end else if (want.truncated) begin
                    truncated_seen++;
                end
            end
        end
    end

    // watchdog: counts cycles in which neither a segment nor a point is accepted
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_point_valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        t_seg_in                seg;
        t_point_out             pt;
        logic [STRIDE_BITS-1:0] value;
        int                     failures;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_seg          = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        stride_reg     = STRIDE_RESET;
        idle_pct       = 0;
        mismatches     = 0;
        points_checked = 0;
        truncated_seen = 0;
        segments_sent  = 0;
        strides_used   = 0;
        quiet_cycles   = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part runs on the stride left by reset
        for (int row = 0; row < NUM_DIR; row++) begin
            seg.start_x   = COORD_BITS'(DIR_TAB[row][0]);
            seg.start_y   = COORD_BITS'(DIR_TAB[row][1]);
            seg.end_x     = COORD_BITS'(DIR_TAB[row][2]);
            seg.end_y     = COORD_BITS'(DIR_TAB[row][3]);
            pt.point_x    = COORD_BITS'(DIR_TAB[row][5]);
            pt.point_y    = COORD_BITS'(DIR_TAB[row][6]);
            pt.last_point = DIR_TAB[row][7] != 0;
            pt.truncated  = DIR_TAB[row][8] != 0;
            send_segment(seg, DIR_TAB[row][4] != 0, pt);
        end

        // random phases over several strides, zero and 255 among them
        for (int p = 0; p < NUM_PHASES; p++) begin
            value = (PHASE_STRIDE[p] < 0) ? STRIDE_BITS'($urandom_range(1, 255))
                                          : STRIDE_BITS'(PHASE_STRIDE[p]);
            write_stride(value);
            idle_pct = PHASE_IDLE[p];
            repeat (PHASE_ITEMS)
                send_segment(random_segment((stride_reg == '0) ? 1 : int'(stride_reg)),
                             1'b0, '0);
        end

        start <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        failures = mismatches + expected_points.size();
        $display("coverage: %0d segments over %0d stride writes, %0d points checked",
                 segments_sent, strides_used, points_checked);
        $display("coverage: %0d segments cut at the point limit, %0d failures",
                 truncated_seen, failures);
        if (failures == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
